// ----- hw/rtl/prt_pkg.sv -----
`default_nettype none

package prt_pkg;

  localparam int PEER_SLOTS_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;

  localparam int NUM_EVENTS = 6;

  localparam logic [2:0] CMD_GOOD       = 3'd0;
  localparam logic [2:0] CMD_RATE       = 3'd1;
  localparam logic [2:0] CMD_INVALID    = 3'd2;
  localparam logic [2:0] CMD_SIGFAIL    = 3'd3;
  localparam logic [2:0] CMD_DISCONNECT = 3'd4;
  localparam logic [2:0] CMD_TRUST      = 3'd5;
  localparam logic [2:0] CMD_QUERY      = 3'd6;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_SCORE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGFAIL_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVALID_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_LIMIT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNBLOCK_SCORE = 3'd4;

  localparam logic signed [7:0] SCORE_MAX = 8'sd100;
  localparam logic signed [7:0] SCORE_MIN = -8'sd100;

  localparam logic signed [7:0] BLOCK_SCORE_RST   = -8'sd60;
  localparam logic [15:0]       SIGFAIL_LIMIT_RST = 16'd3;
  localparam logic [15:0]       INVALID_LIMIT_RST = 16'd6;
  localparam logic [15:0]       RATE_LIMIT_RST    = 16'd10;
  localparam logic signed [7:0] UNBLOCK_SCORE_RST = -8'sd20;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        peer_index;
    logic signed [7:0] delta;
  } prt_in_t;

  typedef struct packed {
    logic signed [7:0] score_after;
    logic              blocked;
    logic              known;
    logic [15:0]       event_count;
  } prt_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/peer_reputation_table_top.sv -----
`default_nettype none

// Peer reputation table. One entry per peer slot holds the known flag, the
// block mark, the clamped score and six saturating event counters, all in a
// single one-port-read, one-port-write synchronous memory. An accepted item
// reads its entry at the accepting edge into rd_data. Once the output is free,
// the updated entry is written back and the result is registered into
// out_data, raising out_valid. The sustained rate is one item per cycle while
// out_stall does not hold the output, set by the single memory
// read-modify-write. A write-to-read bypass covers consecutive items on the
// same slot. After reset the memory is cleared one entry per cycle over all
// PEER_SLOTS entries, with in_stall held high. Configuration writes are taken
// during that pass. Write configuration only while no item is in flight.
module peer_reputation_table_top #(
  parameter int PEER_SLOTS = prt_pkg::PEER_SLOTS_DEF,
  parameter int COUNT_BITS = prt_pkg::COUNT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  prt_pkg::prt_in_t                    in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output prt_pkg::prt_out_t                   out_data,
  input  wire                                 cfg_wen,
  input  wire [prt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [prt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import prt_pkg::*;

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int LW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(PEER_SLOTS - 1);
  localparam logic [16:0]      SLOTS_EXT = 17'(PEER_SLOTS);

  typedef struct packed {
    logic                                 known;
    logic                                 blocked;
    logic signed [7:0]                    score;
    logic [NUM_EVENTS-1:0][COUNT_BITS-1:0] cnt;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic signed [7:0] block_score;
  logic [15:0]       sigfail_limit;
  logic [15:0]       invalid_limit;
  logic [15:0]       rate_limit;
  logic signed [7:0] unblock_score;

  logic [EW-1:0] mem [PEER_SLOTS];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] fwd_data;
  logic          rd_hit;

  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;

  logic             s1_valid;
  prt_in_t          s1_item;
  logic [IDX_W-1:0] s1_addr;
  logic             s1_in_range;

  logic             out_free;
  logic             s1_fire;
  logic             in_fire;
  logic             wr_en;
  logic [IDX_W-1:0] in_addr;
  logic             in_range;
  entry_t           ent_new;
  prt_out_t         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_score   <= BLOCK_SCORE_RST;
      sigfail_limit <= SIGFAIL_LIMIT_RST;
      invalid_limit <= INVALID_LIMIT_RST;
      rate_limit    <= RATE_LIMIT_RST;
      unblock_score <= UNBLOCK_SCORE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BLOCK_SCORE:   block_score   <= cfg_data[7:0];
        REG_SIGFAIL_LIMIT: sigfail_limit <= cfg_data;
        REG_INVALID_LIMIT: invalid_limit <= cfg_data;
        REG_RATE_LIMIT:    rate_limit    <= cfg_data;
        REG_UNBLOCK_SCORE: unblock_score <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_addr  = 17'({9'd0, in_data.peer_index}) < SLOTS_EXT ?
                    IDX_W'({9'd0, in_data.peer_index}) : '0;
  assign in_range = {9'd0, in_data.peer_index} < SLOTS_EXT;
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = clr_active || (s1_valid && !out_free);
  assign in_fire  = in_valid && !in_stall;
  assign wr_en    = s1_fire && s1_in_range && (s1_item.cmd <= CMD_TRUST);

  // memory: cleared after reset, then one read and one write a cycle
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[s1_addr] <= ent_new;
    end
    if (in_fire) begin
      rd_data <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == LAST_SLOT) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // bypass: the read at this edge misses the write at the same edge
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_data <= ent_new;
    end
    if (in_fire) begin
      rd_hit      <= wr_en && (s1_addr == in_addr);
      s1_item     <= in_data;
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
    end
  end

  always_comb begin
    entry_t                ent;
    logic [COUNT_BITS-1:0] c_old;
    logic [COUNT_BITS-1:0] c_new;
    logic signed [8:0]     s_raw;
    logic signed [7:0]     s_clamp;
    logic                  is_event;
    logic                  blk;
    ent      = rd_hit ? entry_t'(fwd_data) : entry_t'(rd_data);
    ent_new  = ent;
    is_event = s1_item.cmd <= CMD_TRUST;
    c_old    = '0;
    case (s1_item.cmd)
      CMD_GOOD:       c_old = ent.cnt[0];
      CMD_RATE:       c_old = ent.cnt[1];
      CMD_INVALID:    c_old = ent.cnt[2];
      CMD_SIGFAIL:    c_old = ent.cnt[3];
      CMD_DISCONNECT: c_old = ent.cnt[4];
      CMD_TRUST:      c_old = ent.cnt[5];
      default:        c_old = '0;
    endcase
    c_new = (c_old == '1) ? c_old : c_old + 1'b1;
    case (s1_item.cmd)
      CMD_GOOD:       ent_new.cnt[0] = c_new;
      CMD_RATE:       ent_new.cnt[1] = c_new;
      CMD_INVALID:    ent_new.cnt[2] = c_new;
      CMD_SIGFAIL:    ent_new.cnt[3] = c_new;
      CMD_DISCONNECT: ent_new.cnt[4] = c_new;
      CMD_TRUST:      ent_new.cnt[5] = c_new;
      default: ;
    endcase
    s_raw = 9'(ent.score) + 9'(s1_item.delta);
    if (s_raw > 9'(SCORE_MAX)) begin
      s_clamp = SCORE_MAX;
    end else if (s_raw < 9'(SCORE_MIN)) begin
      s_clamp = SCORE_MIN;
    end else begin
      s_clamp = s_raw[7:0];
    end
    blk = ent.blocked;
    if (s1_item.cmd == CMD_TRUST && s_raw > 9'(unblock_score)) begin
      blk = 1'b0;
    end
    if (s_clamp <= block_score ||
        LW'(ent_new.cnt[3]) >= LW'(sigfail_limit) ||
        LW'(ent_new.cnt[2]) >= LW'(invalid_limit) ||
        LW'(ent_new.cnt[1]) >= LW'(rate_limit)) begin
      blk = 1'b1;
    end
    ent_new.known   = 1'b1;
    ent_new.score   = s_clamp;
    ent_new.blocked = blk;

    result = '0;
    if (s1_in_range) begin
      if (is_event) begin
        result.score_after = ent_new.score;
        result.blocked     = ent_new.blocked;
        result.known       = 1'b1;
        result.event_count = 16'(LW'(c_new));
      end else begin
        result.score_after = ent.score;
        result.blocked     = ent.blocked;
        result.known       = ent.known;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/reputation_checker.sv -----
module reputation_checker
  import prt_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  input  wire                       in_stall,
  input  prt_in_t                   in_data,
  input  wire                       out_valid,
  input  wire                       out_stall,
  input  prt_out_t                  out_data,
  input  wire                       cfg_wen,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                      rep_known   [PEER_SLOTS_DEF];
  logic signed [7:0]         rep_score   [PEER_SLOTS_DEF];
  logic                      rep_blocked [PEER_SLOTS_DEF];
  logic [COUNT_BITS_DEF-1:0] ev_count    [NUM_EVENTS][PEER_SLOTS_DEF];

  logic signed [7:0] block_lvl;
  logic signed [7:0] unblock_lvl;
  logic [15:0]       sigfail_lim;
  logic [15:0]       invalid_lim;
  logic [15:0]       rate_lim;

  prt_out_t expected_replies[$];
  prt_out_t exp_r;
  prt_out_t pred_r;
  int       err_cnt;

  function automatic prt_out_t apply_peer_cmd(prt_in_t it);
    int       slot;
    int       ev;
    int       s;
    logic [15:0] c;
    prt_out_t r;
    slot = int'(it.peer_index);
    c = '0;
    // cmd 7 falls through as a query
    if (it.cmd <= CMD_TRUST) begin
      ev = int'(it.cmd);
      if (ev_count[ev][slot] != '1) ev_count[ev][slot] = ev_count[ev][slot] + 1'b1;
      c = ev_count[ev][slot];
      rep_known[slot] = 1'b1;
      s = int'(rep_score[slot]) + int'(it.delta);
      if (it.cmd == CMD_TRUST && s > int'(unblock_lvl)) rep_blocked[slot] = 1'b0;
      if (s > int'(SCORE_MAX)) s = int'(SCORE_MAX);
      if (s < int'(SCORE_MIN)) s = int'(SCORE_MIN);
      rep_score[slot] = s[7:0];
      if (s <= int'(block_lvl) ||
          ev_count[CMD_SIGFAIL][slot] >= sigfail_lim ||
          ev_count[CMD_INVALID][slot] >= invalid_lim ||
          ev_count[CMD_RATE][slot] >= rate_lim)
        rep_blocked[slot] = 1'b1;
    end
    r.score_after = rep_score[slot];
    r.blocked     = rep_blocked[slot];
    r.known       = rep_known[slot];
    r.event_count = c;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (rep_known[i]) begin
        rep_known[i]   = 1'b0;
        rep_score[i]   = '0;
        rep_blocked[i] = 1'b0;
      end
      foreach (ev_count[e, i]) ev_count[e][i] = '0;
      block_lvl   = BLOCK_SCORE_RST;
      sigfail_lim = SIGFAIL_LIMIT_RST;
      invalid_lim = INVALID_LIMIT_RST;
      rate_lim    = RATE_LIMIT_RST;
      unblock_lvl = UNBLOCK_SCORE_RST;
      expected_replies.delete();
      err_cnt = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_BLOCK_SCORE:   block_lvl   = cfg_data[7:0];
          REG_SIGFAIL_LIMIT: sigfail_lim = cfg_data;
          REG_INVALID_LIMIT: invalid_lim = cfg_data;
          REG_RATE_LIMIT:    rate_lim    = cfg_data;
          REG_UNBLOCK_SCORE: unblock_lvl = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pred_r = apply_peer_cmd(in_data);
        expected_replies = {expected_replies, pred_r};
      end
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: score %0d blocked %0b known %0b count %0d",
                     out_data.score_after, out_data.blocked, out_data.known,
                     out_data.event_count);
        end else begin
          exp_r = expected_replies.pop_front();
          if (exp_r.score_after !== out_data.score_after ||
              exp_r.blocked !== out_data.blocked ||
              exp_r.known !== out_data.known ||
              exp_r.event_count !== out_data.event_count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: exp score %0d blocked %0b known %0b count %0d,",
                        " got score %0d blocked %0b known %0b count %0d"},
                       exp_r.score_after, exp_r.blocked, exp_r.known,
                       exp_r.event_count, out_data.score_after, out_data.blocked,
                       out_data.known, out_data.event_count);
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_replies.size();
  end

endmodule

// ----- tb/sv/tb_peer_reputation_table_top.sv -----
module tb_peer_reputation_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import prt_pkg::*;

  localparam int PHASE_LEN = 215;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER [5] = '{
    REG_BLOCK_SCORE, REG_SIGFAIL_LIMIT, REG_INVALID_LIMIT, REG_RATE_LIMIT, REG_UNBLOCK_SCORE
  };

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  prt_in_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  prt_out_t                  out_data;
  logic                      cfg_wen;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  bit tx_idle;
  bit rx_idle;
  int items_sent;
  int settings_used;

  peer_reputation_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reputation_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("peer_reputation_table_top test failed");
    $finish;
  end

  // receiver: random stall before each transfer while rx_idle is set
  initial begin
    int n;
    forever begin
      n = rx_idle ? $urandom_range(4) : 0;
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic prt_in_t mk(logic [2:0] c, logic [7:0] p, logic signed [7:0] d);
    prt_in_t r;
    r.cmd        = c;
    r.peer_index = p;
    r.delta      = d;
    return r;
  endfunction

  // score level with random upper byte
  function automatic logic [15:0] lvl(int v);
    return {8'($urandom_range(255)), 8'(v)};
  endfunction

  function automatic prt_in_t rand_item();
    prt_in_t r;
    int      k;
    k = $urandom_range(99);
    if (k < 80) r.cmd = 3'($urandom_range(CMD_TRUST));
    else r.cmd = 3'($urandom);
    k = $urandom_range(99);
    if (k < 40) r.peer_index = 8'($urandom_range(3));
    else if (k < 65) r.peer_index = 8'(252 + $urandom_range(3));
    else r.peer_index = 8'($urandom);
    k = $urandom_range(99);
    if (k < 50) r.delta = 8'(int'($urandom_range(20)) - 10);
    else r.delta = 8'($urandom);
    return r;
  endfunction

  task automatic send(prt_in_t it);
    int gap;
    gap = tx_idle ? $urandom_range(4) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                               logic [15:0] v3, logic [15:0] v4);
    logic [15:0] vals [5];
    vals = '{v0, v1, v2, v3, v4};
    for (int i = 0; i < 5; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wen   <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    apply_setting(lvl(BLOCK_SCORE_RST), SIGFAIL_LIMIT_RST, INVALID_LIMIT_RST,
                  RATE_LIMIT_RST, lvl(UNBLOCK_SCORE_RST));

    send(mk(CMD_QUERY, 8'd0, 8'sd0));
    send(mk(CMD_GOOD, 8'd0, 8'sd127));
    send(mk(CMD_GOOD, 8'd0, 8'sd127));
    send(mk(CMD_QUERY, 8'd0, 8'h80));
    send(mk(CMD_DISCONNECT, 8'd255, 8'h80));
    send(mk(CMD_TRUST, 8'd255, 8'sd127));
    send(mk(CMD_TRUST, 8'd255, 8'h80));
    send(mk(3'b111, 8'd255, 8'sd127));
    repeat (3) send(mk(CMD_SIGFAIL, 8'd1, 8'sd0));
    send(mk(CMD_TRUST, 8'd1, 8'sd50));
    repeat (6) send(mk(CMD_INVALID, 8'd2, 8'sd1));
    send(mk(CMD_RATE, 8'd3, -8'sd1));
    send(mk(CMD_RATE, 8'd3, -8'sd1));
    send(mk(CMD_QUERY, 8'd3, 8'sd0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(lvl(BLOCK_SCORE_RST), SIGFAIL_LIMIT_RST, INVALID_LIMIT_RST,
                         RATE_LIMIT_RST, lvl(UNBLOCK_SCORE_RST));
        1: apply_setting(lvl(SCORE_MIN), 16'hFFFF, 16'hFFFF, 16'hFFFF, lvl(SCORE_MAX));
        2: apply_setting(lvl(SCORE_MAX), 16'd1, 16'd1, 16'd1, lvl(SCORE_MIN));
        3: apply_setting(lvl(-128), 16'd0, 16'd0, 16'd0, lvl(127));
        4: apply_setting(lvl(int'($urandom_range(200)) - 100), 16'($urandom_range(1, 8)),
                         16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                         lvl(int'($urandom_range(200)) - 100));
        default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom_range(3)),
                               16'($urandom_range(4, 12)), 16'($urandom));
      endcase
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 32 == 0) begin
          tx_idle = ($urandom_range(3) != 0);
          rx_idle = ($urandom_range(3) != 0);
        end
        send(rand_item());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d items transferred under %0d register settings, all commands and levels",
             items_sent, settings_used);
    $display("both sides idled up to four cycles, including zero and out-of-range limits");
    if (mismatches == 0 && outstanding == 0) begin
      $display("peer_reputation_table_top test passed");
    end else begin
      $display("peer_reputation_table_top test failed");
    end
    $finish;
  end

endmodule
